// ===== rtl/segment_tree_max_pair_sum_unit_assert.svh =====
// Assertion macros shared by the checker of the segment tree unit.
`ifndef SEGMENT_TREE_MAX_PAIR_SUM_UNIT_ASSERT_SVH
`define SEGMENT_TREE_MAX_PAIR_SUM_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STMPS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment tree unit: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define STMPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment tree unit: assertion failed");

`endif

// ===== rtl/stmps_pkg.sv =====
// Types and constants shared by the segment tree max pair sum unit.
package stmps_pkg;

  localparam int IDX_W   = 11;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = VALUE_W + 1;
  // A tree over at most 2047 positions is 11 levels deep, so node numbers fit in 12 bits.
  localparam int K_W     = IDX_W + 1;

  localparam logic [IDX_W-1:0] COUNT_RESET = IDX_W'(1024);

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                      command;
    logic [IDX_W-1:0]          index_a;
    logic [IDX_W-1:0]          index_b;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   best_pair_sum;
    logic signed [VALUE_W-1:0] range_max;
    logic                      range_error;
  } out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   best;
    logic signed [VALUE_W-1:0] largest;
  } pair_t;

endpackage

// ===== rtl/stmps_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module stmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/stmps_merge.sv =====
// Combines the summaries of two disjoint ranges into the summary of their union.
module stmps_merge
  import stmps_pkg::*;
(
  input  pair_t lhs,
  input  pair_t rhs,
  output pair_t y
);

  logic signed [SUM_W-1:0]   cross_sum;
  logic signed [SUM_W-1:0]   best_lr;
  logic signed [VALUE_W-1:0] l_max;
  logic signed [VALUE_W-1:0] r_max;
  logic signed [SUM_W-1:0]   l_best;
  logic signed [SUM_W-1:0]   r_best;

  always_comb begin
    l_max     = lhs.largest;
    r_max     = rhs.largest;
    l_best    = lhs.best;
    r_best    = rhs.best;
    cross_sum = SUM_W'(l_max) + SUM_W'(r_max);
    best_lr   = (l_best > r_best) ? l_best : r_best;
    y.largest = (l_max > r_max) ? l_max : r_max;
    y.best    = (cross_sum > best_lr) ? cross_sum : best_lr;
  end

endmodule

// ===== rtl/segment_tree_max_pair_sum_unit.sv =====
// Segment tree unit: point sets and range queries of the best pair sum and the range maximum.
//
// Input channel (in_valid, in_stall, in_data): a transaction is taken when in_valid is high
// and in_stall is low. A set (command 0) writes one element and gives no result; a query
// (command 1) gives exactly one result on the output channel (out_valid, out_stall, out_data).
// A query with a bad range returns range_error with both values zero; a set outside
// positions 1..n is dropped. n is the cfg_data value written with cfg_write, limited to
// MAX_ELEMENTS and to 2047, and is 1024 after reset.
// One transaction is worked at a time; in_stall stays high until it is done. A set walks
// down to its leaf in one cycle per level, then back to the root level by level, each
// level a sibling read from the node RAM (S_SET_UP_RD) followed by a merge and write
// (S_SET_UP_MRG). A query walks at most the two boundary paths, one level a cycle,
// with each covering node read and merged behind the walk; a query with a bad range
// goes straight to the result state.
// Results sit in an output register, so a new transaction is taken while a result waits.
// A stalled result holds; a finished query waits for the register to free up.
// Reset (rst, synchronous) starts a clearing pass that zeroes all TREE_NODES words of the
// node RAM; in_stall is high throughout.
module segment_tree_max_pair_sum_unit
  import stmps_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  parameter int TREE_NODES   = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_data
);

  localparam int AW = $clog2(TREE_NODES);
  localparam int MAX_N_INT = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;
  localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_N_INT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TREE_NODES - 1);
  localparam logic [K_W-1:0] ROOT = K_W'(1);
  localparam logic [IDX_W-1:0] POS_ONE = IDX_W'(1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SET_DOWN,
    S_SET_UP_RD,
    S_SET_UP_MRG,
    S_Q_DOWN,
    S_Q_LEFT,
    S_Q_RIGHT,
    S_Q_DRAIN,
    S_RESULT
  } state_t;

  function automatic logic node_ok(input logic [K_W-1:0] x);
    return 32'(x) < 32'(TREE_NODES);
  endfunction

  state_t                    state, state_next;
  logic [AW-1:0]             clr_addr, clr_addr_next;
  logic [IDX_W-1:0]          count_reg;
  logic [K_W-1:0]            k, k_next;
  logic [IDX_W-1:0]          lo, lo_next;
  logic [IDX_W-1:0]          hi, hi_next;
  logic [IDX_W-1:0]          pos_a, pos_a_next;
  logic [IDX_W-1:0]          pos_b, pos_b_next;
  logic signed [VALUE_W-1:0] val, val_next;
  logic [K_W-1:0]            rk, rk_next;
  logic [IDX_W-1:0]          rlo, rlo_next;
  logic [IDX_W-1:0]          rhi, rhi_next;
  pair_t                     acc, acc_next;
  logic                      acc_valid, acc_valid_next;
  logic                      inc_pend, inc_pend_next;
  logic                      inc_zero, inc_zero_next;
  logic                      err, err_next;
  logic                      out_valid_next;
  out_t                      out_data_next;

  logic [IDX_W-1:0]          n_active;
  logic [IDX_W:0]            lo_hi_sum;
  logic [IDX_W-1:0]          mid;
  logic [K_W-1:0]            k_left;
  logic [K_W-1:0]            k_right;
  logic [K_W-1:0]            k_parent;
  logic                      inc_issue;
  logic [K_W-1:0]            inc_node;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  pair_t                     ram_wdata;
  pair_t                     ram_rdata;
  pair_t                     rd_pair;
  pair_t                     merged;
  logic                      out_free;

  stmps_ram #(
    .WIDTH($bits(pair_t)),
    .DEPTH(TREE_NODES)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(AW'(inc_node)),
    .rdata(ram_rdata)
  );

  // Nodes past the end of the store read as zero.
  assign rd_pair = inc_zero ? '0 : ram_rdata;

  stmps_merge u_merge (
    .lhs(acc),
    .rhs(rd_pair),
    .y  (merged)
  );

  assign n_active  = (count_reg > MAX_N) ? MAX_N : count_reg;
  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = lo_hi_sum[IDX_W:1];
  assign k_left    = {k[K_W-2:0], 1'b0};
  assign k_right   = {k[K_W-2:0], 1'b1};
  assign k_parent  = {1'b0, k[K_W-1:1]};
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    k_next         = k;
    lo_next        = lo;
    hi_next        = hi;
    pos_a_next     = pos_a;
    pos_b_next     = pos_b;
    val_next       = val;
    rk_next        = rk;
    rlo_next       = rlo;
    rhi_next       = rhi;
    acc_next       = acc;
    acc_valid_next = acc_valid;
    err_next       = err;
    inc_issue      = 1'b0;
    inc_node       = k;
    ram_we         = 1'b0;
    ram_waddr      = AW'(k);
    ram_wdata      = merged;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;

    // A node read issued last cycle is folded into the accumulator now.
    if (inc_pend) begin
      acc_next       = acc_valid ? merged : rd_pair;
      acc_valid_next = 1'b1;
    end

    unique case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          k_next     = ROOT;
          lo_next    = POS_ONE;
          hi_next    = n_active;
          pos_a_next = in_data.index_a;
          pos_b_next = in_data.index_b;
          val_next   = in_data.value;
          if (in_data.command == CMD_SET) begin
            if (in_data.index_a != '0 && in_data.index_a <= n_active) begin
              state_next = S_SET_DOWN;
            end
          end else if (in_data.index_a == '0 || in_data.index_a > in_data.index_b ||
                       in_data.index_b > n_active) begin
            err_next   = 1'b1;
            acc_next   = '0;
            state_next = S_RESULT;
          end else begin
            err_next       = 1'b0;
            acc_valid_next = 1'b0;
            state_next     = S_Q_DOWN;
          end
        end
      end
      S_SET_DOWN: begin
        if (lo == hi) begin
          ram_we         = node_ok(k);
          ram_wdata      = '{best: SUM_W'(val), largest: val};
          acc_next       = node_ok(k) ? ram_wdata : '0;
          acc_valid_next = 1'b1;
          state_next     = S_SET_UP_RD;
        end else if (pos_a <= mid) begin
          k_next  = k_left;
          hi_next = mid;
        end else begin
          k_next  = k_right;
          lo_next = mid + POS_ONE;
        end
      end
      S_SET_UP_RD: begin
        if (k == ROOT) begin
          state_next = S_IDLE;
        end else begin
          inc_issue  = 1'b1;
          inc_node   = {k[K_W-1:1], ~k[0]};
          state_next = S_SET_UP_MRG;
        end
      end
      S_SET_UP_MRG: begin
        ram_we    = node_ok(k_parent);
        ram_waddr = AW'(k_parent);
        if (!node_ok(k_parent)) begin
          acc_next = '0;
        end
        k_next     = k_parent;
        state_next = S_SET_UP_RD;
      end
      S_Q_DOWN: begin
        if (lo == pos_a && hi == pos_b) begin
          inc_issue  = 1'b1;
          state_next = S_Q_DRAIN;
        end else if (pos_b <= mid) begin
          k_next  = k_left;
          hi_next = mid;
        end else if (pos_a > mid) begin
          k_next  = k_right;
          lo_next = mid + POS_ONE;
        end else begin
          // The range straddles this node: walk its left edge, then its right edge.
          rk_next    = k_right;
          rlo_next   = mid + POS_ONE;
          rhi_next   = hi;
          k_next     = k_left;
          hi_next    = mid;
          state_next = S_Q_LEFT;
        end
      end
      S_Q_LEFT: begin
        if (lo == pos_a) begin
          inc_issue  = 1'b1;
          k_next     = rk;
          lo_next    = rlo;
          hi_next    = rhi;
          state_next = S_Q_RIGHT;
        end else if (pos_a > mid) begin
          k_next  = k_right;
          lo_next = mid + POS_ONE;
        end else begin
          inc_issue = 1'b1;
          inc_node  = k_right;
          k_next    = k_left;
          hi_next   = mid;
        end
      end
      S_Q_RIGHT: begin
        if (hi == pos_b) begin
          inc_issue  = 1'b1;
          state_next = S_Q_DRAIN;
        end else if (pos_b <= mid) begin
          k_next  = k_left;
          hi_next = mid;
        end else begin
          inc_issue = 1'b1;
          inc_node  = k_left;
          k_next    = k_right;
          lo_next   = mid + POS_ONE;
        end
      end
      S_Q_DRAIN: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '{best_pair_sum: acc.best, range_max: acc.largest,
                             range_error: err};
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    inc_pend_next = inc_issue;
    inc_zero_next = !node_ok(inc_node);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count_reg <= COUNT_RESET;
      inc_pend  <= 1'b0;
      acc_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      inc_pend  <= inc_pend_next;
      acc_valid <= acc_valid_next;
      out_valid <= out_valid_next;
      if (cfg_write) begin
        count_reg <= cfg_data;
      end
    end
    k        <= k_next;
    lo       <= lo_next;
    hi       <= hi_next;
    pos_a    <= pos_a_next;
    pos_b    <= pos_b_next;
    val      <= val_next;
    rk       <= rk_next;
    rlo      <= rlo_next;
    rhi      <= rhi_next;
    acc      <= acc_next;
    inc_zero <= inc_zero_next;
    err      <= err_next;
    out_data <= out_data_next;
  end

endmodule

// ===== rtl/stmps_checker.sv =====
// Port-level checker for the segment tree unit, bound to the top level.
`include "segment_tree_max_pair_sum_unit_assert.svh"

module stmps_checker
  import stmps_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic signed [SUM_W-1:0] max_ext;
  logic signed [SUM_W-1:0] max_twice;
  logic                    sum_in_bound;
  logic                    err_fields_zero;

  assign max_ext         = SUM_W'(out_data.range_max);
  assign max_twice       = {out_data.range_max, 1'b0};
  assign sum_in_bound    = (out_data.best_pair_sum <= max_ext) ||
                           (out_data.best_pair_sum <= max_twice);
  assign err_fields_zero = (out_data.best_pair_sum == '0) && (out_data.range_max == '0);

  // A result that is held back stays offered.
  `STMPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // An error result carries zero in both value fields.
  `STMPS_ASSERT_SAME(a_err_zero, clk, rst, out_valid && out_data.range_error, err_fields_zero)

  // A pair sum never exceeds the larger of the maximum itself and twice the maximum.
  `STMPS_ASSERT_SAME(a_sum_bound, clk, rst, out_valid && !out_data.range_error, sum_in_bound)

  // The node store is being cleared right after reset, so no transaction is taken.
  `STMPS_ASSERT_SAME(a_clear_stall, clk, rst, $past(rst), in_stall)

endmodule

bind segment_tree_max_pair_sum_unit stmps_checker u_stmps_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
